>>> hdl/pts_pkg.sv
// Shared types and constants of the prefix traffic statistics block.
package pts_pkg;

	localparam int unsigned PREFIXES_DEF = 64;
	localparam int unsigned CLASS_CNT    = 4;
	localparam int unsigned RES_DEPTH    = 4;
	localparam logic [15:0] ALPHA_RST    = 16'd58982;

	// action codes of an input item
	localparam logic [1:0] ACT_DATA   = 2'd0;
	localparam logic [1:0] ACT_LOSS   = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	localparam logic [1:0] IDLE_SAT = 2'd2;

	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,
		CMD_LOSS = 2'd1,
		CMD_UPD  = 2'd2
	} cmd_kind_t;

	// mask bit 0 wired, 1 wifi, 2 cellular, 3 all
	typedef struct packed {
		cmd_kind_t   kind;
		logic [5:0]  prefix;
		logic [3:0]  mask;
		logic [15:0] size;
		logic [15:0] rtt;
		logic [47:0] now;
	} cmd_t;

	typedef struct packed {
		logic [31:0] pkt;
		logic [47:0] bytes;
		logic [31:0] loss;
		logic [1:0]  idle;
		logic [31:0] lat;
		logic [31:0] thr;
		logic [15:0] lrate;
	} cls_rec_t;

	typedef struct packed {
		logic [47:0]                  last_time;
		cls_rec_t [CLASS_CNT-1:0]     cls;
	} row_t;

	typedef struct packed {
		logic [5:0]  prefix;
		logic [1:0]  tclass;
		logic [31:0] lat;
		logic [31:0] thr;
		logic [15:0] lrate;
		logic        last;
	} res_t;

endpackage

>>> hdl/pts_ram.sv
// Generic single write port, single read port RAM with registered read.
module pts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/pts_front.sv
// Front end: accepts items, drops ignored ones, queues commands for the back end.
module pts_front #(
	parameter int unsigned PREFIXES = pts_pkg::PREFIXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         action,
	input  logic [5:0]         prefix_index,
	input  logic               on_wired,
	input  logic               on_wifi,
	input  logic               on_cellular,
	input  logic               include_all,
	input  logic [15:0]        pkt_len,
	input  logic [15:0]        rtt,
	input  logic [47:0]        now,
	input  logic               clearing,
	output logic               cmd_empty,
	input  logic               cmd_pop,
	output pts_pkg::cmd_t      cmd
);

	localparam logic [16:0] PFX_LIM = 17'(PREFIXES);

	pts_pkg::cmd_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          accept;
	logic          keep;
	pts_pkg::cmd_t cls_cmd;

	assign full   = clearing || (cnt_q == 2'd2);
	assign accept = push && !full;

	always_comb begin
		cls_cmd.prefix = prefix_index;
		cls_cmd.mask   = {include_all, on_cellular, on_wifi, on_wired};
		cls_cmd.size   = pkt_len;
		cls_cmd.rtt    = rtt;
		cls_cmd.now    = now;
		cls_cmd.kind   = pts_pkg::CMD_DATA;
		keep           = ({11'd0, prefix_index} < PFX_LIM);
		unique case (action)
			pts_pkg::ACT_DATA: begin
				cls_cmd.kind = pts_pkg::CMD_DATA;
				keep         = keep && (cls_cmd.mask != 4'd0);
			end
			pts_pkg::ACT_LOSS: begin
				cls_cmd.kind = pts_pkg::CMD_LOSS;
				keep         = keep && (cls_cmd.mask != 4'd0);
			end
			pts_pkg::ACT_UPDATE: begin
				cls_cmd.kind = pts_pkg::CMD_UPD;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			q_q[wr_q] <= cls_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept && keep) begin
				wr_q <= !wr_q;
			end
			if (cmd_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(accept && keep) - 2'(cmd_pop);
		end
	end

	assign cmd_empty = (cnt_q == 2'd0);
	assign cmd       = q_q[rd_q];

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !accept)
		else $error("item accepted during clearing pass");

endmodule

>>> hdl/pts_div.sv
// Restoring divider, one quotient bit per cycle.
module pts_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [47:0] den,
	output logic        done,
	output logic [47:0] quo
);

	logic [47:0] quo_q;
	logic [47:0] rem_q;
	logic [47:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [48:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, quo_q[47]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[46:0], ge};
			rem_q <= ge ? 48'(rem_sh - {1'b0, den_q}) : rem_sh[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

>>> hdl/pts_back.sv
// Back end: per-prefix read-modify-write sequencer and result queue.
module pts_back #(
	parameter int unsigned PREFIXES = pts_pkg::PREFIXES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    alpha,
	input  logic           cmd_empty,
	input  pts_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           clearing,
	output logic           res_empty,
	input  logic           res_pop,
	output pts_pkg::res_t  res
);

	localparam int unsigned AW    = (PREFIXES > 1) ? $clog2(PREFIXES) : 1;
	localparam int unsigned RW    = $bits(pts_pkg::row_t);
	localparam int unsigned RPW   = $clog2(pts_pkg::RES_DEPTH);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_RD    = 15'b000000000000100,
		S_DCLS  = 15'b000000000001000,
		S_DA    = 15'b000000000010000,
		S_DB    = 15'b000000000100000,
		S_UCLS  = 15'b000000001000000,
		S_UDIV1 = 15'b000000010000000,
		S_UTA   = 15'b000000100000000,
		S_UTB   = 15'b000001000000000,
		S_UDIV2 = 15'b000010000000000,
		S_ULA   = 15'b000100000000000,
		S_ULB   = 15'b001000000000000,
		S_UEMIT = 15'b010000000000000,
		S_WR    = 15'b100000000000000
	} state_t;

	state_t            state_q;
	pts_pkg::cmd_t     cmd_q;
	pts_pkg::row_t     row_q;
	pts_pkg::row_t     rd_row;
	pts_pkg::row_t     row_nx;
	pts_pkg::cls_rec_t rec;
	logic [1:0]        cls_q;
	logic [47:0]       interval_q;
	logic [48:0]       prod_q;
	logic [31:0]       thr_smp_q;
	logic [15:0]       loss_smp_q;
	logic [AW-1:0]     clr_cnt_q;

	logic [16:0]       mul_a;
	logic [31:0]       mul_b;
	logic [48:0]       mul_p;
	logic [49:0]       ew_sum;
	logic [31:0]       ew_res;
	logic [1:0]        idle_nx;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [RW-1:0]     ram_wdata;
	logic [RW-1:0]     ram_rdata;

	logic              div_start;
	logic [47:0]       div_num;
	logic [47:0]       div_den;
	logic              div_done;
	logic [47:0]       div_quo;
	logic [46:0]       loss_x;
	logic              loss_go;

	pts_pkg::res_t     rq_q [pts_pkg::RES_DEPTH];
	logic [RPW-1:0]    rq_wr_q;
	logic [RPW-1:0]    rq_rd_q;
	logic [RPW:0]      rq_cnt_q;
	logic              rq_full;
	logic              res_push;
	pts_pkg::res_t     res_new;

	assign rd_row   = pts_pkg::row_t'(ram_rdata);
	assign rec      = row_q.cls[cls_q];
	assign clearing = (state_q == S_CLEAR);
	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty;

	// memory: one row per prefix, all four classes plus the update time
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_cnt_q : AW'(cmd_q.prefix);
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : RW'(row_q);

	pts_ram #(
		.WIDTH (RW),
		.DEPTH (PREFIXES)
	) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd_pop),
		.raddr (AW'(cmd.prefix)),
		.rdata (ram_rdata)
	);

	// row as loaded: a loss bumps every tagged class at once, an update takes the new time
	always_comb begin
		row_nx = rd_row;
		if (cmd_q.kind == pts_pkg::CMD_UPD) begin
			row_nx.last_time = cmd_q.now;
		end
		for (int i = 0; i < pts_pkg::CLASS_CNT; i++) begin
			if ((cmd_q.kind == pts_pkg::CMD_LOSS) && cmd_q.mask[i]) begin
				row_nx.cls[i].loss = rd_row.cls[i].loss + 32'd1;
			end
		end
	end

	// shared EWMA multiplier: A step alpha*old, B step (1-alpha)*sample + acc
	always_comb begin
		mul_a = {1'b0, alpha};
		unique case (state_q)
			S_DA:    mul_b = rec.lat;
			S_UTA:   mul_b = rec.thr;
			S_DB: begin
				mul_a = 17'h10000 - {1'b0, alpha};
				mul_b = {8'd0, cmd_q.rtt, 8'd0};
			end
			S_UTB: begin
				mul_a = 17'h10000 - {1'b0, alpha};
				mul_b = thr_smp_q;
			end
			S_ULB: begin
				mul_a = 17'h10000 - {1'b0, alpha};
				mul_b = {16'd0, loss_smp_q};
			end
			default: mul_b = {16'd0, rec.lrate};
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	assign ew_sum  = {1'b0, prod_q} + {1'b0, mul_p} + 50'd32768;
	assign ew_res  = ew_sum[47:16];
	assign idle_nx = (rec.idle < pts_pkg::IDLE_SAT) ? rec.idle + 2'd1 : rec.idle;

	// divider feed: bytes/interval, then losses*25600/packets
	assign loss_x    = {15'd0, rec.loss} * 47'd25600;
	assign loss_go   = (rec.loss != 32'd0) && (rec.pkt != 32'd0);
	assign div_start = (state_q == S_UCLS) || ((state_q == S_UTB) && loss_go);
	assign div_num   = (state_q == S_UCLS) ? rec.bytes : {1'b0, loss_x};
	assign div_den   = (state_q == S_UCLS) ? interval_q : {16'd0, rec.pkt};

	pts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign res_new.prefix = cmd_q.prefix;
	assign res_new.tclass = cls_q;
	assign res_new.lat    = rec.lat;
	assign res_new.thr    = rec.thr;
	assign res_new.lrate  = rec.lrate;
	assign res_new.last   = (cls_q == 2'(pts_pkg::CLASS_CNT - 1));
	assign rq_full        = (rq_cnt_q == (RPW+1)'(pts_pkg::RES_DEPTH));
	assign res_push       = (state_q == S_UEMIT) && !rq_full;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_q <= cmd;
				end
			end
			S_RD: begin
				cls_q      <= 2'd0;
				row_q      <= row_nx;
				interval_q <= cmd_q.now - rd_row.last_time;
			end
			S_DCLS: begin
				if (!cmd_q.mask[cls_q]) begin
					cls_q <= cls_q + 2'd1;
				end
			end
			S_DA, S_UTA, S_ULA: begin
				prod_q <= mul_p;
			end
			S_DB: begin
				row_q.cls[cls_q].pkt   <= rec.pkt + 32'd1;
				row_q.cls[cls_q].bytes <= rec.bytes + {32'd0, cmd_q.size};
				row_q.cls[cls_q].lat   <= ew_res;
				row_q.cls[cls_q].idle  <= 2'd0;
				cls_q                  <= cls_q + 2'd1;
			end
			S_UDIV1: begin
				thr_smp_q <= (div_quo[47:31] != 17'd0) ? 32'hFFFF_FFFF
				                                      : {div_quo[30:0], 1'b0};
			end
			S_UTB: begin
				row_q.cls[cls_q].thr <= ew_res;
				if (!loss_go) begin
					loss_smp_q <= 16'd0;
				end
			end
			S_UDIV2: begin
				loss_smp_q <= (div_quo[47:16] != 32'd0) ? 16'hFFFF : div_quo[15:0];
			end
			S_ULB: begin
				row_q.cls[cls_q].lrate <= ew_res[15:0];
				row_q.cls[cls_q].idle  <= idle_nx;
				if (idle_nx == pts_pkg::IDLE_SAT) begin
					row_q.cls[cls_q].lat <= 32'd0;
				end
				row_q.cls[cls_q].pkt   <= 32'd0;
				row_q.cls[cls_q].bytes <= 48'd0;
				row_q.cls[cls_q].loss  <= 32'd0;
			end
			S_UEMIT: begin
				if (res_push) begin
					cls_q <= cls_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(PREFIXES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!cmd_empty) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					unique case (cmd_q.kind)
						pts_pkg::CMD_DATA: state_q <= S_DCLS;
						pts_pkg::CMD_LOSS: state_q <= S_WR;
						default: begin
							state_q <= (rd_row.last_time == cmd_q.now) ? S_IDLE : S_UCLS;
						end
					endcase
				end
				S_DCLS: begin
					if (cmd_q.mask[cls_q]) begin
						state_q <= S_DA;
					end else if (cls_q == 2'(pts_pkg::CLASS_CNT - 1)) begin
						state_q <= S_WR;
					end
				end
				S_DA: state_q <= S_DB;
				S_DB: begin
					state_q <= (cls_q == 2'(pts_pkg::CLASS_CNT - 1)) ? S_WR : S_DCLS;
				end
				S_UCLS: state_q <= S_UDIV1;
				S_UDIV1: begin
					if (div_done) begin
						state_q <= S_UTA;
					end
				end
				S_UTA: state_q <= S_UTB;
				S_UTB: state_q <= loss_go ? S_UDIV2 : S_ULA;
				S_UDIV2: begin
					if (div_done) begin
						state_q <= S_ULA;
					end
				end
				S_ULA: state_q <= S_ULB;
				S_ULB: state_q <= S_UEMIT;
				S_UEMIT: begin
					if (res_push) begin
						state_q <= (cls_q == 2'(pts_pkg::CLASS_CNT - 1)) ? S_WR : S_UCLS;
					end
				end
				S_WR: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[rq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (res_push) begin
				rq_wr_q <= rq_wr_q + RPW'(1);
			end
			if (res_pop && !res_empty) begin
				rq_rd_q <= rq_rd_q + RPW'(1);
			end
			rq_cnt_q <= rq_cnt_q + (RPW+1)'(res_push) - (RPW+1)'(res_pop && !res_empty);
		end
	end

	assign res_empty = (rq_cnt_q == '0);
	assign res       = rq_q[rq_rd_q];

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !rq_full)
		else $error("result queue overrun");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> (state_q == S_RD))
		else $error("command taken outside idle");

endmodule

>>> hdl/prefix_traffic_stats_unit.sv
// Top level of the per-prefix traffic statistics block.
//
//  channel | handshake        | payload
//  --------+------------------+-------------------------------------------------
//  input   | push / full      | action, prefix_index, on_*, include_all,
//          |                  | pkt_len, rtt, now
//  result  | empty / pop      | out_prefix, traffic_class, mean_latency,
//          |                  | mean_throughput, mean_loss_rate, last
//  config  | alpha_we         | alpha_wdata
//
// After reset the row memory is swept to zero, row by row, with full high.
// A data item runs a multiply pair per tagged class; a loss item goes from read to write-back.
// An update runs a throughput division per class, plus a loss-rate division for each class
// with losses and packets, each of 48 steps on the one-bit-a-cycle divider.
// A two-item command queue lets input items land while the back end works;
// a four-item result queue decouples the sequencer from pop, and the sequencer
// waits for pop only when that queue is full.
module prefix_traffic_stats_unit #(
	parameter int unsigned PREFIXES = pts_pkg::PREFIXES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        push,
	output logic        full,
	input  logic [1:0]  action,
	input  logic [5:0]  prefix_index,
	input  logic        on_wired,
	input  logic        on_wifi,
	input  logic        on_cellular,
	input  logic        include_all,
	input  logic [15:0] pkt_len,
	input  logic [15:0] rtt,
	input  logic [47:0] now,
	// configuration
	input  logic        alpha_we,
	input  logic [15:0] alpha_wdata,
	// result items
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  out_prefix,
	output logic [1:0]  traffic_class,
	output logic [31:0] mean_latency,
	output logic [31:0] mean_throughput,
	output logic [15:0] mean_loss_rate,
	output logic        last
);

	logic          [15:0] alpha_q;
	logic                 clearing;
	logic                 cmd_empty;
	logic                 cmd_pop;
	pts_pkg::cmd_t        cmd;
	pts_pkg::res_t        res;

	// EWMA weight of the old value, Q0.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= pts_pkg::ALPHA_RST;
		end else if (alpha_we) begin
			alpha_q <= alpha_wdata;
		end
	end

	pts_front #(
		.PREFIXES (PREFIXES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.action       (action),
		.prefix_index (prefix_index),
		.on_wired     (on_wired),
		.on_wifi      (on_wifi),
		.on_cellular  (on_cellular),
		.include_all  (include_all),
		.pkt_len      (pkt_len),
		.rtt          (rtt),
		.now          (now),
		.clearing     (clearing),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd)
	);

	pts_back #(
		.PREFIXES (PREFIXES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.alpha     (alpha_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.res_empty (empty),
		.res_pop   (pop),
		.res       (res)
	);

	assign out_prefix      = res.prefix;
	assign traffic_class   = res.tclass;
	assign mean_latency    = res.lat;
	assign mean_throughput = res.thr;
	assign mean_loss_rate  = res.lrate;
	assign last            = res.last;

endmodule

>>> bench/tb_top.sv
// Testbench for prefix_traffic_stats_unit: directed table plus random traffic checked by a predictor.
module tb_top;

	localparam int unsigned NPFX     = 64;
	localparam int unsigned IDLE_LIM = 20000;   // cycles with no handshake
	localparam int unsigned DRAIN    = 600;     // long enough for one update to finish

	typedef struct {
		logic [1:0]  act;
		logic [5:0]  pfx;
		logic [3:0]  tags;
		logic [15:0] size;
		logic [15:0] rtt;
		logic [47:0] tnow;
	} evt_t;

	typedef struct {
		logic [5:0]  pfx;
		logic [1:0]  tcls;
		logic [31:0] lat;
		logic [31:0] thr;
		logic [15:0] lrate;
		logic        last;
	} stat_t;

	logic        clk, arst_n;
	logic        push, full, empty, pop;
	logic [1:0]  action;
	logic [5:0]  prefix_index;
	logic        on_wired, on_wifi, on_cellular, include_all;
	logic [15:0] pkt_len, rtt;
	logic [47:0] now;
	logic        alpha_we;
	logic [15:0] alpha_wdata;
	logic [5:0]  out_prefix;
	logic [1:0]  traffic_class;
	logic [31:0] mean_latency, mean_throughput;
	logic [15:0] mean_loss_rate;
	logic        last;

	prefix_traffic_stats_unit dut (
		.clk, .arst_n, .push, .full, .action, .prefix_index, .on_wired, .on_wifi,
		.on_cellular, .include_all, .pkt_len, .rtt, .now, .alpha_we, .alpha_wdata,
		.empty, .pop, .out_prefix, .traffic_class, .mean_latency, .mean_throughput,
		.mean_loss_rate, .last
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// shadow of the statistics table
	logic [15:0] m_alpha;
	logic [31:0] m_pkt   [NPFX*4];
	logic [47:0] m_bytes [NPFX*4];
	logic [31:0] m_loss  [NPFX*4];
	logic [1:0]  m_idle  [NPFX*4];
	logic [31:0] m_lat   [NPFX*4];
	logic [31:0] m_thr   [NPFX*4];
	logic [15:0] m_lrate [NPFX*4];
	logic [47:0] m_tlast [NPFX];

	stat_t       pending_stats[$];
	int          errors;
	int unsigned idle_cycles;
	logic [47:0] clock_ticks;     // running time base for updates

	function automatic logic [63:0] blend(logic [63:0] old, logic [63:0] sample);
		logic [63:0] a;
		a = {48'd0, m_alpha};
		return (a * old + (64'd65536 - a) * sample + 64'd32768) >> 16;
	endfunction

	task automatic predict_stats(input evt_t ev);
		int          e;
		logic [63:0] interval, thr, loss;
		stat_t       s;
		if (ev.pfx >= NPFX) return;
		case (ev.act)
			pts_pkg::ACT_DATA: begin
				for (int c = 0; c < 4; c++) begin
					e = ev.pfx * 4 + c;
					if (ev.tags[c]) begin
						m_pkt[e]   = m_pkt[e] + 32'd1;
						m_bytes[e] = m_bytes[e] + {32'd0, ev.size};
						m_lat[e]   = 32'(blend({32'd0, m_lat[e]}, {40'd0, ev.rtt, 8'd0}));
						m_idle[e]  = 2'd0;
					end
				end
			end
			pts_pkg::ACT_LOSS: begin
				for (int c = 0; c < 4; c++) begin
					e = ev.pfx * 4 + c;
					if (ev.tags[c]) m_loss[e] = m_loss[e] + 32'd1;
				end
			end
			pts_pkg::ACT_UPDATE: begin
				if (ev.tnow == m_tlast[ev.pfx]) return;
				interval = {16'd0, ev.tnow - m_tlast[ev.pfx]};
				for (int c = 0; c < 4; c++) begin
					e = ev.pfx * 4 + c;
					thr = 0;
					loss = 0;
					if (m_bytes[e] != 0) begin
						thr = ({16'd0, m_bytes[e]} / interval) * 2;
						if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
					end
					m_thr[e] = 32'(blend({32'd0, m_thr[e]}, thr));
					if (m_loss[e] != 0 && m_pkt[e] != 0) begin
						loss = ({32'd0, m_loss[e]} * 64'd25600) / {32'd0, m_pkt[e]};
						if (loss > 64'hFFFF) loss = 64'hFFFF;
					end
					m_lrate[e] = 16'(blend({48'd0, m_lrate[e]}, loss));
					if (m_idle[e] < pts_pkg::IDLE_SAT) m_idle[e]++;
					if (m_idle[e] == pts_pkg::IDLE_SAT) m_lat[e] = 0;
					m_bytes[e] = 0;
					m_loss[e]  = 0;
					m_pkt[e]   = 0;
					s.pfx   = ev.pfx;
					s.tcls  = c[1:0];
					s.lat   = m_lat[e];
					s.thr   = m_thr[e];
					s.lrate = m_lrate[e];
					s.last  = (c == 3);
					pending_stats.push_back(s);
				end
				m_tlast[ev.pfx] = ev.tnow;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// result side: random stall pattern, compare on each pop
	logic [7:0] stall_pat;
	always @(posedge clk) begin
		stat_t s;
		if (arst_n && pop && !empty) begin
			if (pending_stats.size() == 0) begin
				report_mismatch("unexpected result item", 48'(out_prefix), 48'd0);
			end else begin
				s = pending_stats.pop_front();
				if (out_prefix !== s.pfx)
					report_mismatch("out_prefix", 48'(out_prefix), 48'(s.pfx));
				if (traffic_class !== s.tcls)
					report_mismatch("traffic_class", 48'(traffic_class), 48'(s.tcls));
				if (mean_latency !== s.lat)
					report_mismatch("mean_latency", 48'(mean_latency), 48'(s.lat));
				if (mean_throughput !== s.thr)
					report_mismatch("mean_throughput", 48'(mean_throughput), 48'(s.thr));
				if (mean_loss_rate !== s.lrate)
					report_mismatch("mean_loss_rate", 48'(mean_loss_rate), 48'(s.lrate));
				if (last !== s.last) report_mismatch("last", 48'(last), 48'(s.last));
			end
		end
		if (!arst_n) begin
			pop       <= 1'b0;
			stall_pat <= 8'h5A;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_pat <= $urandom;
			else stall_pat <= {stall_pat[6:0], stall_pat[7]};
			pop <= stall_pat[0] | ($urandom_range(0, 3) == 0);
		end
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIM) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// drives one item; returns once it has been accepted
	task automatic send_item(input evt_t ev);
		push         <= 1'b1;
		action       <= ev.act;
		prefix_index <= ev.pfx;
		{include_all, on_cellular, on_wifi, on_wired} <= ev.tags;
		pkt_len      <= ev.size;
		rtt          <= ev.rtt;
		now          <= ev.tnow;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_stats(ev);
	endtask

	task automatic idle_gap(input int n);
		push <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_alpha(input logic [15:0] a);
		alpha_we    <= 1'b1;
		alpha_wdata <= a;
		@(posedge clk);
		alpha_we    <= 1'b0;
		m_alpha = a;
	endtask

	function automatic evt_t make_evt(logic [1:0] act, logic [5:0] pfx, logic [3:0] tags,
			logic [15:0] size, logic [15:0] r, logic [47:0] t);
		evt_t ev;
		ev.act = act; ev.pfx = pfx; ev.tags = tags;
		ev.size = size; ev.rtt = r; ev.tnow = t;
		return ev;
	endfunction

	// random item: mostly traffic on a few prefixes, updates with advancing time
	function automatic evt_t rand_evt();
		evt_t ev;
		int   k;
		k = $urandom_range(0, 99);
		ev.pfx  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
		ev.tags = 4'($urandom);
		ev.size = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
		ev.rtt  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
		ev.tnow = {16'($urandom), 32'($urandom)};
		if (k < 55) ev.act = pts_pkg::ACT_DATA;
		else if (k < 75) ev.act = pts_pkg::ACT_LOSS;
		else if (k < 97) ev.act = pts_pkg::ACT_UPDATE;
		else ev.act = pts_pkg::ACT_NONE;
		if (ev.act == pts_pkg::ACT_UPDATE) begin
			case ($urandom_range(0, 9))
				0: ev.tnow = m_tlast[ev.pfx];                 // no time passed
				1, 2: ev.tnow = 48'($urandom);                // random jumps within 32 bits
				3: ev.tnow = m_tlast[ev.pfx] + 48'd1;
				default: begin
					clock_ticks = clock_ticks + 48'($urandom_range(1, 4000));
					ev.tnow = clock_ticks;
				end
			endcase
			if ($urandom_range(0, 15) == 0) ev.tnow = {16'($urandom), 32'($urandom)};
		end
		return ev;
	endfunction

	// directed table: extremes, every action, each special case
	evt_t dir_tab[$];
	stat_t s0;

	initial begin
		arst_n = 1'b0; push = 1'b0; alpha_we = 1'b0; alpha_wdata = '0;
		action = '0; prefix_index = '0; on_wired = 0; on_wifi = 0; on_cellular = 0;
		include_all = 0; pkt_len = '0; rtt = '0; now = '0;
		errors = 0; clock_ticks = 48'd100;
		m_alpha = pts_pkg::ALPHA_RST;
		for (int i = 0; i < NPFX*4; i++) begin
			m_pkt[i] = 0; m_bytes[i] = 0; m_loss[i] = 0; m_idle[i] = 0;
			m_lat[i] = 0; m_thr[i] = 0; m_lrate[i] = 0;
		end
		for (int i = 0; i < NPFX; i++) m_tlast[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// an idle prefix after reset reports all zeros; check the typed-in values
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd63, 4'hF, 16'd0, 16'd0, 48'd1));
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd63, 4'hF, 16'd0, 16'd0,
			48'd1));                                                             // same time
		dir_tab.push_back(make_evt(pts_pkg::ACT_NONE, 6'd0, 4'hF, 16'hFFFF, 16'hFFFF,
			48'hFFFF_FFFF_FFFF));
		dir_tab.push_back(make_evt(pts_pkg::ACT_DATA, 6'd0, 4'h0, 16'hFFFF, 16'hFFFF,
			48'd0));                                                             // no tags
		dir_tab.push_back(make_evt(pts_pkg::ACT_LOSS, 6'd0, 4'h0, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_DATA, 6'd0, 4'hF, 16'hFFFF, 16'hFFFF, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_DATA, 6'd0, 4'h5, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_DATA, 6'd0, 4'hA, 16'd1, 16'd1, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_LOSS, 6'd0, 4'hF, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_LOSS, 6'd0, 4'h9, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_LOSS, 6'd0, 4'h9, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd0, 4'h0, 16'd0, 16'd0,
			48'd1));                                                             // short interval
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd0, 4'h0, 16'd0, 16'd0,
			48'd2));                                                             // idle, latency clears
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd0, 4'h0, 16'd0, 16'd0,
			48'd3));                                                             // latency stays clear
		dir_tab.push_back(make_evt(pts_pkg::ACT_DATA, 6'd1, 4'hF, 16'hFFFF, 16'd300, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd1, 4'hF, 16'd0, 16'd0,
			48'hFFFF_FFFF_FFFF));                                                // max interval
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd1, 4'hF, 16'd0, 16'd0,
			48'd5));                                                             // wraps
		dir_tab.push_back(make_evt(pts_pkg::ACT_LOSS, 6'd2, 4'hF, 16'd0, 16'd0, 48'd0));
		dir_tab.push_back(make_evt(pts_pkg::ACT_UPDATE, 6'd2, 4'hF, 16'd0, 16'd0,
			48'd7));                                                             // loss, no pkts

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i]);
			if (i == 0) begin
				// overwrite predicted values with the obvious ones
				for (int c = 0; c < 4; c++) begin
					s0.pfx = 6'd63; s0.tcls = c[1:0]; s0.lat = 0; s0.thr = 0;
					s0.lrate = 0; s0.last = (c == 3);
					pending_stats[c] = s0;
				end
			end
		end
		wait_drained();

		// random phases over several alpha settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_alpha(16'd0);
				1: set_alpha(16'hFFFF);
				2: set_alpha(16'h8000);
				3: set_alpha(16'($urandom));
				default: set_alpha(pts_pkg::ALPHA_RST);
			endcase
			for (int n = 0; n < 84;) begin
				int burst;
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && n < 84; b++, n++) send_item(rand_evt());
				if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 20));
				if (n > 40 && n <= 52) begin
					// sender holds off until all results are out
					push <= 1'b0;
					@(posedge clk);
					while (pending_stats.size() != 0) @(posedge clk);
				end
			end
			wait_drained();
		end

		if (errors == 0 && pending_stats.size() == 0) begin
			$display("tb_top OK");
		end else begin
			if (pending_stats.size() != 0)
				$display("%0d result items never arrived", pending_stats.size());
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule

>>> prefix_traffic_stats_unit.f
hdl/pts_pkg.sv
hdl/pts_ram.sv
hdl/pts_front.sv
hdl/pts_div.sv
hdl/pts_back.sv
hdl/prefix_traffic_stats_unit.sv
bench/tb_top.sv
